// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;

    // Table sizing
    localparam int NUM_SEMS    = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int PID_WIDTH   = 8;

    localparam int SLOT_W    = $clog2(NUM_SEMS);
    localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Field widths of the words on the two channels
    localparam int OP_W     = 3;
    localparam int HANDLE_W = 4;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 16;
    localparam int PID_IN_W = 8;
    localparam int STATUS_W = 3;

    localparam logic [VALUE_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN   = 3'd0,
        OP_WAIT   = 3'd1,
        OP_POST   = 3'd2,
        OP_CLOSE  = 3'd3,
        OP_REMOVE = 3'd4,
        OP_QUERY  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_INVALID = 3'd2,
        ST_NOSLOT  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NSCAN,
        S_OPEN,
        S_EXEC,
        S_QRD,
        S_POP,
        S_WSLOT,
        S_WRD,
        S_WCMP,
        S_DONE,
        S_BAD
    } t_state;

    // Kind of result word the datapath forms, with its state update
    typedef enum logic [2:0] {
        EM_OPEN,
        EM_WAIT,
        EM_POST,
        EM_CLOSE,
        EM_POP,
        EM_DONE,
        EM_BAD
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  idx_inc;
        logic  sel_handle;
        logic  sel_name;
        logic  sel_inc;
        logic  rd_head;
        logic  rd_walk;
        logic  qi_clr;
        logic  walk_step;
        logic  emit;
        t_emit emit_kind;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            by_name;
        logic            name_hit;
        logic            idx_last;
        logic            sel_ok;
        logic            q_empty;
        logic            pop_last;
        logic            w_active;
        logic            walk_last;
        logic            sel_last;
        logic            out_free;
    } t_stat;

    // Circular queue index: head plus an offset, modulo the queue depth.
    function automatic logic [QIDX_W-1:0] wrap(input logic [QIDX_W-1:0] head,
                                               input logic [QCNT_W-1:0] off);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W + 1)'(head) + (QCNT_W + 1)'(off);
        if (sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[QIDX_W-1:0];
    endfunction

    // Wait-queue memory address of one entry of one semaphore.
    function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [QIDX_W-1:0] idx);
        logic [MEM_AW-1:0] a;
        a = MEM_AW'(MEM_AW'(slot) * MEM_AW'(QUEUE_DEPTH)) + MEM_AW'(idx);
        return a;
    endfunction

endpackage

// ===== rtl/core/cst_if.sv =====
// Request channel: one operation word.
interface cst_req_if;
    import cst_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic                by_name;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    name_key;
    logic [VALUE_W-1:0]  init_value;
    logic [PID_IN_W-1:0] pid;

    modport source (output valid, operation, by_name, handle, name_key, init_value, pid,
                    input ready);
    modport sink (input valid, operation, by_name, handle, name_key, init_value, pid,
                  output ready);
endinterface

// Result channel: one result word.
interface cst_res_if;
    import cst_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic                woken_valid;
    logic [PID_IN_W-1:0] woken_pid;
    logic                is_blocked;
    logic                last;

    modport source (output valid, status, handle_out, woken_valid, woken_pid, is_blocked,
                    last, input ready);
    modport sink (input valid, status, handle_out, woken_valid, woken_pid, is_blocked,
                  last, output ready);
endinterface

// ===== rtl/core/cst_ctrl.sv =====
module cst_ctrl import cst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencing of each operation and the commands to the datapath
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.emit_kind = EM_BAD;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_OPEN: begin
                        n_state = i_stat.by_name ? S_NSCAN : S_OPEN;
                    end
                    OP_WAIT, OP_POST, OP_CLOSE: begin
                        if (i_stat.by_name) begin
                            n_state = S_NSCAN;
                        end else begin
                            o_cmd.sel_handle = 1'b1;
                            n_state          = S_EXEC;
                        end
                    end
                    OP_REMOVE, OP_QUERY: begin
                        n_state = S_WSLOT;
                    end
                    default: begin
                        n_state = S_BAD;
                    end
                endcase
            end
            S_NSCAN: begin
                // One name entry a cycle, stopping at the first match or at the last entry.
                if (i_stat.name_hit || i_stat.idx_last) begin
                    o_cmd.sel_name = 1'b1;
                    n_state        = (i_stat.op == OP_OPEN) ? S_OPEN : S_EXEC;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_OPEN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_OPEN;
                    n_state         = S_IDLE;
                end
            end
            S_EXEC: begin
                if (!i_stat.sel_ok) begin
                    n_state = S_BAD;
                end else if (i_stat.op == OP_WAIT) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = EM_WAIT;
                        n_state         = S_IDLE;
                    end
                end else if (!i_stat.q_empty) begin
                    n_state = S_QRD;
                end else if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = (i_stat.op == OP_POST) ? EM_POST : EM_CLOSE;
                    n_state         = S_IDLE;
                end
            end
            S_QRD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_POP;
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_POP;
                    if (i_stat.op == OP_CLOSE && !i_stat.pop_last) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WSLOT: begin
                // Walk every slot; only non-empty queues of used slots are read.
                if (i_stat.w_active) begin
                    o_cmd.qi_clr = 1'b1;
                    n_state      = S_WRD;
                end else if (i_stat.sel_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.sel_inc = 1'b1;
                end
            end
            S_WRD: begin
                o_cmd.rd_walk = 1'b1;
                n_state       = S_WCMP;
            end
            S_WCMP: begin
                o_cmd.walk_step = 1'b1;
                if (!i_stat.walk_last) begin
                    n_state = S_WRD;
                end else if (i_stat.sel_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.sel_inc = 1'b1;
                    n_state       = S_WSLOT;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_DONE;
                    n_state         = S_IDLE;
                end
            end
            S_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_BAD;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/cst_dp.sv =====
module cst_dp import cst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OP_W-1:0]     i_operation,
    input  logic                i_by_name,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [KEY_W-1:0]    i_name_key,
    input  logic [VALUE_W-1:0]  i_init_value,
    input  logic [PID_IN_W-1:0] i_pid,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic                o_woken_valid,
    output logic [PID_IN_W-1:0] o_woken_pid,
    output logic                o_is_blocked,
    output logic                o_last
);

    // Latched request word
    logic [OP_W-1:0]      r_op;
    logic                 r_by_name;
    logic [HANDLE_W-1:0]  r_handle;
    logic [KEY_W-1:0]     r_key;
    logic [VALUE_W-1:0]   r_init;
    logic [PID_WIDTH-1:0] r_pid;

    // Semaphore and name tables
    logic [NUM_SEMS-1:0]  r_slot_used;
    logic [VALUE_W-1:0]   r_count    [NUM_SEMS];
    logic [QIDX_W-1:0]    r_head     [NUM_SEMS];
    logic [QCNT_W-1:0]    r_wcnt     [NUM_SEMS];
    logic [NUM_SEMS-1:0]  r_name_used;
    logic [KEY_W-1:0]     r_name_key [NUM_SEMS];
    logic [SLOT_W-1:0]    r_name_hdl [NUM_SEMS];

    // Wait-queue memory
    logic [PID_WIDTH-1:0] mem [MEM_DEPTH];
    logic [PID_WIDTH-1:0] r_qdata;

    // Working registers
    logic [SLOT_W-1:0]    r_idx;
    logic [SLOT_W-1:0]    r_sel;
    logic                 r_sel_ok;
    logic [QCNT_W-1:0]    r_qi;
    logic [QCNT_W-1:0]    r_keep;
    logic                 r_blk;

    // Output register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [HANDLE_W-1:0]  r_handle_out;
    logic                 r_woken_valid;
    logic [PID_IN_W-1:0]  r_woken_pid;
    logic                 r_is_blocked;
    logic                 r_last;

    logic [15:0]          w_pid_ext;
    logic [7:0]           w_hdl_ext;
    logic                 w_hdl_ok;
    logic [SLOT_W-1:0]    w_hsel;
    logic                 w_name_hit;
    logic [SLOT_W-1:0]    w_nhdl;
    logic [QIDX_W-1:0]    w_head;
    logic [QCNT_W-1:0]    w_wcnt;
    logic [VALUE_W-1:0]   w_count;
    logic                 w_q_full;
    logic [SLOT_W-1:0]    w_fs;
    logic                 w_fs_ok;
    logic [SLOT_W-1:0]    w_fn;
    logic                 w_fn_ok;
    logic                 w_alloc;
    logic                 w_match;
    logic [QCNT_W-1:0]    w_keep_nx;
    logic                 w_is_close;
    logic                 w_emit_wait;
    logic                 w_block;
    logic                 w_grant;
    logic                 w_pop;
    logic                 w_free;
    logic                 w_we;
    logic [MEM_AW-1:0]    w_waddr;
    logic [PID_WIDTH-1:0] w_wdata;
    logic [MEM_AW-1:0]    w_raddr;
    logic [7:0]           w_sel_ext;
    logic [7:0]           w_fs_ext;
    logic [15:0]          w_qd_ext;
    logic [STATUS_W-1:0]  e_status;
    logic [HANDLE_W-1:0]  e_handle;
    logic                 e_wv;
    logic [PID_IN_W-1:0]  e_wp;
    logic                 e_blk;
    logic                 e_last;

    // Field conversions and lookups at the current slot and name entry
    assign w_pid_ext  = 16'(i_pid);
    assign w_hdl_ext  = 8'(r_handle);
    assign w_hdl_ok   = w_hdl_ext < 8'(NUM_SEMS);
    assign w_hsel     = w_hdl_ext[SLOT_W-1:0];
    assign w_name_hit = r_name_used[r_idx] && (r_name_key[r_idx] == r_key);
    assign w_nhdl     = r_name_hdl[r_idx];
    assign w_head     = r_head[r_sel];
    assign w_wcnt     = r_wcnt[r_sel];
    assign w_count    = r_count[r_sel];
    assign w_q_full   = w_wcnt == QCNT_W'(QUEUE_DEPTH);
    assign w_match    = r_qdata == r_pid;
    assign w_keep_nx  = w_match ? r_keep : r_keep + 1'b1;
    assign w_is_close = r_op == OP_CLOSE;
    assign w_sel_ext  = 8'(r_sel);
    assign w_fs_ext   = 8'(w_fs);
    assign w_qd_ext   = 16'(r_qdata);

    // Lowest free slot and lowest free name entry
    always_comb begin
        w_fs    = '0;
        w_fs_ok = 1'b0;
        w_fn    = '0;
        w_fn_ok = 1'b0;
        for (int i = NUM_SEMS - 1; i >= 0; i--) begin
            if (!r_slot_used[i]) begin
                w_fs    = SLOT_W'(i);
                w_fs_ok = 1'b1;
            end
            if (!r_name_used[i]) begin
                w_fn    = SLOT_W'(i);
                w_fn_ok = 1'b1;
            end
        end
    end

    // Decisions taken when a result word is formed
    assign w_alloc = i_cmd.emit && (i_cmd.emit_kind == EM_OPEN) && !(r_by_name && r_sel_ok)
                     && w_fs_ok && (!r_by_name || w_fn_ok);
    assign w_emit_wait = i_cmd.emit && (i_cmd.emit_kind == EM_WAIT);
    assign w_grant = w_emit_wait && (w_count != '0);
    assign w_block = w_emit_wait && (w_count == '0) && !w_q_full;
    assign w_pop   = i_cmd.emit && (i_cmd.emit_kind == EM_POP);
    assign w_free  = (i_cmd.emit && (i_cmd.emit_kind == EM_CLOSE))
                     || (w_pop && w_is_close && (w_wcnt == QCNT_W'(1)));

    // Memory port addresses: a blocked wait appends, a remove walk compacts in place
    assign w_we    = w_block || (i_cmd.walk_step && (r_op == OP_REMOVE) && !w_match);
    assign w_waddr = w_block ? mem_addr(r_sel, wrap(w_head, w_wcnt))
                             : mem_addr(r_sel, wrap(w_head, r_keep));
    assign w_wdata = w_block ? r_pid : r_qdata;
    assign w_raddr = i_cmd.rd_head ? mem_addr(r_sel, w_head)
                                   : mem_addr(r_sel, wrap(w_head, r_qi));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_head || i_cmd.rd_walk) begin
            r_qdata <= mem[w_raddr];
        end
    end

    // Result word fields
    always_comb begin
        e_status = ST_OK;
        e_handle = w_sel_ext[HANDLE_W-1:0];
        e_wv     = 1'b0;
        e_wp     = '0;
        e_blk    = 1'b0;
        e_last   = 1'b1;
        case (i_cmd.emit_kind)
            EM_OPEN: begin
                if (r_by_name && r_sel_ok) begin
                    e_handle = w_sel_ext[HANDLE_W-1:0];
                end else if (!w_fs_ok || (r_by_name && !w_fn_ok)) begin
                    e_status = ST_NOSLOT;
                    e_handle = '0;
                end else begin
                    e_handle = w_fs_ext[HANDLE_W-1:0];
                end
            end
            EM_WAIT: begin
                if (w_count != '0) begin
                    e_status = ST_OK;
                end else if (w_q_full) begin
                    e_status = ST_FULL;
                end else begin
                    e_status = ST_BLOCKED;
                end
            end
            EM_POST, EM_CLOSE: begin
                e_status = ST_OK;
            end
            EM_POP: begin
                e_wv   = 1'b1;
                e_wp   = w_qd_ext[PID_IN_W-1:0];
                e_last = w_is_close ? (w_wcnt == QCNT_W'(1)) : 1'b1;
            end
            EM_DONE: begin
                e_handle = '0;
                e_blk    = r_blk;
            end
            default: begin
                e_status = ST_INVALID;
                e_handle = '0;
            end
        endcase
    end

    // Request latch and the tables without a reset value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_by_name <= i_by_name;
            r_handle  <= i_handle;
            r_key     <= i_name_key;
            r_init    <= i_init_value;
            r_pid     <= w_pid_ext[PID_WIDTH-1:0];
        end
        if (w_alloc) begin
            r_count[w_fs] <= r_init;
            if (r_by_name) begin
                r_name_key[w_fn] <= r_key;
                r_name_hdl[w_fn] <= w_fs;
            end
        end
        if (w_grant) begin
            r_count[r_sel] <= w_count - 1'b1;
        end
        if (i_cmd.emit && (i_cmd.emit_kind == EM_POST) && (w_count != COUNT_MAX)) begin
            r_count[r_sel] <= w_count + 1'b1;
        end
        if (i_cmd.emit) begin
            r_status      <= e_status;
            r_handle_out  <= e_handle;
            r_woken_valid <= e_wv;
            r_woken_pid   <= e_wp;
            r_is_blocked  <= e_blk;
            r_last        <= e_last;
        end
    end

    // Tables with a reset value, working registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_used <= '0;
            r_name_used <= '0;
            for (int i = 0; i < NUM_SEMS; i++) begin
                r_head[i] <= '0;
                r_wcnt[i] <= '0;
            end
            r_idx       <= '0;
            r_sel       <= '0;
            r_sel_ok    <= 1'b0;
            r_qi        <= '0;
            r_keep      <= '0;
            r_blk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_sel    <= '0;
                r_sel_ok <= 1'b0;
                r_blk    <= 1'b0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.sel_handle) begin
                r_sel    <= w_hsel;
                r_sel_ok <= w_hdl_ok && r_slot_used[w_hsel];
            end
            if (i_cmd.sel_name) begin
                r_sel    <= w_nhdl;
                r_sel_ok <= w_name_hit && r_slot_used[w_nhdl];
            end
            if (i_cmd.sel_inc) begin
                r_sel <= r_sel + 1'b1;
            end
            if (i_cmd.qi_clr) begin
                r_qi   <= '0;
                r_keep <= '0;
            end
            if (i_cmd.walk_step) begin
                r_qi   <= r_qi + 1'b1;
                r_keep <= w_keep_nx;
                if ((r_op == OP_QUERY) && w_match) begin
                    r_blk <= 1'b1;
                end
                if ((r_op == OP_REMOVE) && o_stat.walk_last) begin
                    r_wcnt[r_sel] <= w_keep_nx;
                end
            end
            if (w_alloc) begin
                r_slot_used[w_fs] <= 1'b1;
                r_head[w_fs]      <= '0;
                r_wcnt[w_fs]      <= '0;
                if (r_by_name) begin
                    r_name_used[w_fn] <= 1'b1;
                end
            end
            if (w_block) begin
                r_wcnt[r_sel] <= w_wcnt + 1'b1;
            end
            if (w_pop) begin
                r_head[r_sel] <= wrap(w_head, QCNT_W'(1));
                r_wcnt[r_sel] <= w_wcnt - 1'b1;
            end
            // Closing frees the slot and every name that maps to it.
            if (w_free) begin
                r_slot_used[r_sel] <= 1'b0;
                r_head[r_sel]      <= '0;
                for (int i = 0; i < NUM_SEMS; i++) begin
                    if (r_name_used[i] && (r_name_hdl[i] == r_sel)) begin
                        r_name_used[i] <= 1'b0;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status back to the controller
    assign o_stat.op        = r_op;
    assign o_stat.by_name   = r_by_name;
    assign o_stat.name_hit  = w_name_hit;
    assign o_stat.idx_last  = r_idx == SLOT_W'(NUM_SEMS - 1);
    assign o_stat.sel_ok    = r_sel_ok;
    assign o_stat.q_empty   = w_wcnt == '0;
    assign o_stat.pop_last  = w_wcnt == QCNT_W'(1);
    assign o_stat.w_active  = r_slot_used[r_sel] && (w_wcnt != '0);
    assign o_stat.walk_last = (r_qi + 1'b1) == w_wcnt;
    assign o_stat.sel_last  = r_sel == SLOT_W'(NUM_SEMS - 1);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_handle_out  = r_handle_out;
    assign o_woken_valid = r_woken_valid;
    assign o_woken_pid   = r_woken_pid;
    assign o_is_blocked  = r_is_blocked;
    assign o_last        = r_last;

endmodule

// ===== rtl/core/counting_semaphore_table.sv =====
// Table of counting semaphores, each with a first-in first-out queue of
// blocked process ids, and a name table mapping 64-bit keys to handles.
// i_req carries one operation word (open, wait, post, close, remove_pid,
// query); o_res returns result words, each with last set on the final one.
// Close returns one word per woken process (one word if none), every other operation one word.
// The block takes one operation at a time; i_req.ready is high while idle.
// Steps per operation, from accept to result registered:
//   open by handle, wait, post with no waiter: latch, decode, execute.
//   named operations: add the name scan, up to NUM_SEMS entries, one entry a cycle.
//   post with a waiter: add a head read and a pop; close: a read and pop per woken process.
//   remove_pid and query: a walk over all NUM_SEMS slots that reads each queued entry
//   from the wait-queue memory, then compares it and, for remove_pid, writes it back.
// The result sits in an output register: the next operation is accepted
// while it waits, and an operation stalls only when it must emit a word
// while the previous one is still held by the receiver.
// Synchronous reset clears all slots, names and queues at once; no sweep.
module counting_semaphore_table import cst_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    cst_req_if.sink   i_req,
    cst_res_if.source o_res
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // Operation sequencer
    cst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Tables, queue memory and result register
    cst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_req.operation),
        .i_by_name     (i_req.by_name),
        .i_handle      (i_req.handle),
        .i_name_key    (i_req.name_key),
        .i_init_value  (i_req.init_value),
        .i_pid         (i_req.pid),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_status      (o_res.status),
        .o_handle_out  (o_res.handle_out),
        .o_woken_valid (o_res.woken_valid),
        .o_woken_pid   (o_res.woken_pid),
        .o_is_blocked  (o_res.is_blocked),
        .o_last        (o_res.last)
    );

    assign i_req.ready = w_in_ready;

endmodule

// ===== rtl/core/cst_checker.sv =====
module cst_checker import cst_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [HANDLE_W-1:0] i_handle_out,
    input logic                i_woken_valid,
    input logic [PID_IN_W-1:0] i_woken_pid,
    input logic                i_is_blocked
);

    // A result word is held until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    // A word without a woken process carries no process id.
    a_woken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_woken_valid |-> i_woken_pid == '0)
        else $error("woken pid set without woken_valid");

    // A positive query answer is a plain status word with no handle or wakeup.
    a_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_blocked |->
            (i_status == ST_OK) && (i_handle_out == '0) && !i_woken_valid)
        else $error("is_blocked set on a word that is not a query answer");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_handle_out  (o_res.handle_out),
    .i_woken_valid (o_res.woken_valid),
    .i_woken_pid   (o_res.woken_pid),
    .i_is_blocked  (o_res.is_blocked)
);
